@@ src/hrrn_pkg.sv @@
// shared constants and codes for the hrrn ready queue selector
`timescale 1ns / 1ps

package hrrn_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int JOB_ID_BITS = 16;
  localparam int TIME_BITS   = 32;

  localparam int EST_BITS    = 16;
  localparam int RATIO_BITS  = 32;
  localparam int STATUS_BITS = 2;
  localparam int CHOSEN_BITS = 16;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int BIT_W = (TIME_BITS > 1) ? $clog2(TIME_BITS) : 1;
  localparam int SUM_BITS = ((TIME_BITS > RATIO_BITS) ? TIME_BITS : RATIO_BITS) + 1;

  // selection policy
  localparam logic FIFO = 1'b0;
  localparam logic HRRN = 1'b1;

  // command codes
  localparam logic CMD_PUSH   = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_PUSHED   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_SELECTED = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd3;

  typedef logic [JOB_ID_BITS-1:0] job_t;
  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [EST_BITS-1:0]    est_t;

endpackage

@@ src/hrrn_ready_queue_selector.sv @@
// hrrn ready queue selector: job table, bit-serial divider and result register
// push and empty select go straight to result; fifo select passes shift first
// hrrn select scans the n stored jobs, then passes shift and result;
//   each job takes one load step, TIME_BITS divider steps and one compare
// one word in flight; the next word is taken in the cycle after its result loads
// reset: policy fifo, table empty, output idle; table payload is not cleared
`timescale 1ns / 1ps

module hrrn_ready_queue_selector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [15:0] in_job_id,
  input  logic [15:0] in_burst_estimate,
  input  logic [31:0] in_current_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_chosen_job,
  output logic [31:0] out_response_ratio
);

  localparam int DEPTH = hrrn_pkg::TABLE_DEPTH;
  localparam int TB    = hrrn_pkg::TIME_BITS;
  localparam int EB    = hrrn_pkg::EST_BITS;
  localparam int IW    = hrrn_pkg::IDX_W;
  localparam int CW    = hrrn_pkg::CNT_W;
  localparam int BW    = hrrn_pkg::BIT_W;
  localparam int SB    = hrrn_pkg::SUM_BITS;
  localparam int RB    = hrrn_pkg::RATIO_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_DIV   = 6'b000100,
    S_CMP   = 6'b001000,
    S_SHIFT = 6'b010000,
    S_RES   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic                        mode_r;
  logic [CW-1:0]               cnt_r;
  hrrn_pkg::job_t              job_r [DEPTH];
  hrrn_pkg::time_t             arr_r [DEPTH];
  hrrn_pkg::est_t              est_r [DEPTH];

  hrrn_pkg::time_t             now_r;
  logic [IW-1:0]               idx_r;
  logic [IW-1:0]               pick_r;
  hrrn_pkg::job_t              pick_job_r;
  hrrn_pkg::time_t             best_r;

  hrrn_pkg::time_t             wait_r;
  hrrn_pkg::time_t             quo_r;
  logic [EB-1:0]               rem_r;
  logic [EB-1:0]               div_est_r;
  logic [BW-1:0]               bit_r;

  logic [hrrn_pkg::STATUS_BITS-1:0] res_status_r;
  hrrn_pkg::job_t              res_job_r;
  logic [RB-1:0]               res_ratio_r;

  logic                        out_valid_r;
  logic [hrrn_pkg::STATUS_BITS-1:0] out_status_r;
  logic [hrrn_pkg::CHOSEN_BITS-1:0] out_job_r;
  logic [RB-1:0]               out_ratio_r;

  logic                        in_fire;
  logic                        full;
  logic                        last_bit;
  logic                        last_entry;
  logic                        take;
  logic                        out_free;
  logic [EB:0]                 rem_sh;
  logic                        q_bit;
  logic [EB-1:0]               rem_diff;
  logic [SB-1:0]               ratio_sum;
  logic [RB-1:0]               ratio_sat;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign full       = (cnt_r >= CW'(DEPTH));
  assign last_bit   = (bit_r == BW'(TB - 1));
  assign last_entry = ((CW'(idx_r) + CW'(1)) == cnt_r);
  assign take       = (idx_r == '0) || (quo_r > best_r);
  assign out_free   = !out_valid_r || out_ready;

  // one restoring divider step per cycle, dividend bits enter msb first
  assign rem_sh   = {rem_r, wait_r[TB-1]};
  assign q_bit    = (rem_sh >= {1'b0, div_est_r});
  assign rem_diff = rem_sh[EB-1:0] - div_est_r;

  // ratio is quotient plus one, saturated to the output width
  assign ratio_sum = SB'(best_r) + SB'(1);
  assign ratio_sat = (ratio_sum > SB'({RB{1'b1}})) ? {RB{1'b1}} : ratio_sum[RB-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_command == hrrn_pkg::CMD_SELECT && cnt_r != '0) begin
            state_nxt = (mode_r == hrrn_pkg::HRRN) ? S_LOAD : S_SHIFT;
          end else begin
            state_nxt = S_RES;
          end
        end
      end
      S_LOAD:  state_nxt = S_DIV;
      S_DIV:   state_nxt = last_bit ? S_CMP : S_DIV;
      S_CMP:   state_nxt = last_entry ? S_SHIFT : S_LOAD;
      S_SHIFT: state_nxt = S_RES;
      S_RES:   state_nxt = out_free ? S_IDLE : S_RES;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= hrrn_pkg::FIFO;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (state_r == S_IDLE && in_fire && in_command == hrrn_pkg::CMD_PUSH && !full) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (state_r == S_SHIFT) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (state_r == S_RES && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath and table payload
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          now_r      <= hrrn_pkg::TIME_BITS'(in_current_time);
          idx_r      <= '0;
          pick_r     <= '0;
          pick_job_r <= job_r[0];
          best_r     <= '0;
          res_job_r  <= '0;
          res_ratio_r <= '0;
          if (in_command == hrrn_pkg::CMD_PUSH) begin
            if (full) begin
              res_status_r <= hrrn_pkg::ST_FULL;
            end else begin
              job_r[cnt_r[IW-1:0]] <= hrrn_pkg::JOB_ID_BITS'(in_job_id);
              arr_r[cnt_r[IW-1:0]] <= hrrn_pkg::TIME_BITS'(in_current_time);
              est_r[cnt_r[IW-1:0]] <= in_burst_estimate;
              res_status_r <= hrrn_pkg::ST_PUSHED;
            end
          end else begin
            res_status_r <= (cnt_r == '0) ? hrrn_pkg::ST_EMPTY : hrrn_pkg::ST_SELECTED;
          end
        end
      end
      S_LOAD: begin
        wait_r    <= now_r - arr_r[idx_r];
        div_est_r <= (est_r[idx_r] == '0) ? EB'(1) : est_r[idx_r];
        rem_r     <= '0;
        quo_r     <= '0;
        bit_r     <= '0;
      end
      S_DIV: begin
        wait_r <= {wait_r[TB-2:0], 1'b0};
        quo_r  <= {quo_r[TB-2:0], q_bit};
        rem_r  <= q_bit ? rem_diff : rem_sh[EB-1:0];
        bit_r  <= bit_r + BW'(1);
      end
      S_CMP: begin
        // strict compare keeps the oldest job on ties
        if (take) begin
          best_r     <= quo_r;
          pick_r     <= idx_r;
          pick_job_r <= job_r[idx_r];
        end
        idx_r <= idx_r + IW'(1);
      end
      S_SHIFT: begin
        // close the gap left by the chosen job
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (IW'(i) >= pick_r) begin
            job_r[i] <= job_r[i+1];
            arr_r[i] <= arr_r[i+1];
            est_r[i] <= est_r[i+1];
          end
        end
        res_job_r   <= pick_job_r;
        res_ratio_r <= (mode_r == hrrn_pkg::HRRN) ? ratio_sat : '0;
      end
      S_RES: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_job_r    <= hrrn_pkg::CHOSEN_BITS'(res_job_r);
          out_ratio_r  <= res_ratio_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_chosen_job     = out_job_r;
  assign out_response_ratio = out_ratio_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("job count above table depth");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_command == hrrn_pkg::CMD_PUSH && !full |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("accepted push did not add a job");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> CW'(idx_r) < cnt_r)
    else $error("scan index past stored jobs");

endmodule

@@ bench/hrrn_ready_queue_selector_tb.sv @@
// self-checking bench for the hrrn ready queue selector: job table model and random traffic
`timescale 1ns / 1ps

module hrrn_ready_queue_selector_tb;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic            command;
    hrrn_pkg::job_t  job_id;
    hrrn_pkg::est_t  estimate;
    hrrn_pkg::time_t now;
  } job_cmd_t;

  typedef struct packed {
    logic [hrrn_pkg::STATUS_BITS-1:0] status;
    logic [hrrn_pkg::CHOSEN_BITS-1:0] chosen;
    logic [hrrn_pkg::RATIO_BITS-1:0]  ratio;
  } pick_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = 1'b0;
  logic [15:0] in_job_id = '0;
  logic [15:0] in_burst_estimate = '0;
  logic [31:0] in_current_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_chosen_job;
  logic [31:0] out_response_ratio;

  // mirror of the ready table
  hrrn_pkg::job_t  tbl_job [hrrn_pkg::TABLE_DEPTH];
  hrrn_pkg::time_t tbl_arrival [hrrn_pkg::TABLE_DEPTH];
  hrrn_pkg::est_t  tbl_est [hrrn_pkg::TABLE_DEPTH];
  int unsigned     tbl_fill = 0;
  logic            policy_now = hrrn_pkg::FIFO;

  job_cmd_t        pending_cmds [$];
  pick_result_t    awaited_picks [$];
  pick_result_t    want;
  job_cmd_t        next_cmd;
  hrrn_pkg::time_t sim_clock = '0;

  bit          in_fire = 1'b0;
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;
  int unsigned ready_pct = 100;
  int unsigned pattern_left = 0;

  int unsigned errors = 0;
  int unsigned words_out = 0;
  int unsigned hrrn_picks = 0;
  int unsigned cycles = 0;
  int unsigned status_seen [4] = '{default: 0};

  hrrn_ready_queue_selector u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_job_id          (in_job_id),
    .in_burst_estimate  (in_burst_estimate),
    .in_current_time    (in_current_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_chosen_job     (out_chosen_job),
    .out_response_ratio (out_response_ratio)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] waited_quotient(input int unsigned slot,
                                                  input hrrn_pkg::time_t now);
    hrrn_pkg::time_t             span;
    logic [hrrn_pkg::EST_BITS:0] divisor;
    // waiting time wraps with the clock
    span = now - tbl_arrival[slot];
    divisor = (tbl_est[slot] == '0) ? (hrrn_pkg::EST_BITS + 1)'(1)
                                    : {1'b0, tbl_est[slot]};
    return span / divisor;
  endfunction

  function automatic pick_result_t predict_pick(input job_cmd_t c);
    pick_result_t r;
    int unsigned  pick;
    int unsigned  i;
    logic [31:0]  best;
    logic [31:0]  q;
    r.status = hrrn_pkg::ST_PUSHED;
    r.chosen = '0;
    r.ratio = '0;
    if (c.command == hrrn_pkg::CMD_PUSH) begin
      if (tbl_fill >= hrrn_pkg::TABLE_DEPTH) begin
        r.status = hrrn_pkg::ST_FULL;
      end else begin
        tbl_job[tbl_fill] = c.job_id;
        tbl_arrival[tbl_fill] = c.now;
        tbl_est[tbl_fill] = c.estimate;
        tbl_fill++;
      end
    end else if (tbl_fill == 0) begin
      r.status = hrrn_pkg::ST_EMPTY;
    end else begin
      pick = 0;
      if (policy_now == hrrn_pkg::HRRN) begin
        best = waited_quotient(0, c.now);
        // strict compare keeps the oldest job on a tie
        for (i = 1; i < tbl_fill; i++) begin
          q = waited_quotient(i, c.now);
          if (q > best) begin
            best = q;
            pick = i;
          end
        end
        r.ratio = (best == '1) ? best : best + 32'd1;
        hrrn_picks++;
      end
      r.status = hrrn_pkg::ST_SELECTED;
      r.chosen = tbl_job[pick];
      for (i = pick; i + 1 < tbl_fill; i++) begin
        tbl_job[i] = tbl_job[i + 1];
        tbl_arrival[i] = tbl_arrival[i + 1];
        tbl_est[i] = tbl_est[i + 1];
      end
      tbl_fill--;
    end
    return r;
  endfunction

  task automatic add_cmd(input logic cmd, input hrrn_pkg::job_t id, input hrrn_pkg::est_t est,
                         input hrrn_pkg::time_t now);
    job_cmd_t c;
    c.command = cmd;
    c.job_id = id;
    c.estimate = est;
    c.now = now;
    pending_cmds.push_back(c);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned seg_left;
    int unsigned push_pct;
    int unsigned r;
    job_cmd_t    c;
    seg_left = 0;
    push_pct = 50;
    repeat (count) begin
      // segments that fill, churn or drain the table
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 20;
        endcase
      end
      seg_left--;
      r = $urandom_range(0, 99);
      if (r >= 95) sim_clock += $urandom;
      else if (r >= 70) sim_clock += $urandom_range(41, 5000);
      else if (r >= 10) sim_clock += $urandom_range(0, 40);
      c.command = ($urandom_range(1, 100) <= push_pct) ? hrrn_pkg::CMD_PUSH
                                                       : hrrn_pkg::CMD_SELECT;
      c.job_id = hrrn_pkg::job_t'($urandom);
      r = $urandom_range(0, 99);
      if (r < 15) c.estimate = '0;
      else if (r < 25) c.estimate = hrrn_pkg::est_t'(1);
      else if (r < 65) c.estimate = hrrn_pkg::est_t'($urandom_range(2, 20));
      else if (r < 90) c.estimate = hrrn_pkg::est_t'($urandom);
      else c.estimate = '1;
      c.now = sim_clock;
      pending_cmds.push_back(c);
    end
  endtask

  task automatic set_policy(input logic mode);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    policy_now = mode;
  endtask

  task automatic drain_block();
    @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || awaited_picks.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sender: record accepted words and predict their results
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire)
      awaited_picks.push_back(predict_pick('{in_command, in_job_id, in_burst_estimate,
                                             in_current_time}));
  end

  // sender: bursts of words with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_command <= next_cmd.command;
        in_job_id <= next_cmd.job_id;
        in_burst_estimate <= next_cmd.estimate;
        in_current_time <= next_cmd.now;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random out_ready whose duty (100, 80, 50 or 25 percent) is redrawn at random intervals
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      pattern_left <= $urandom_range(50, 400);
      case ($urandom_range(0, 3))
        0: ready_pct <= 100;
        1: ready_pct <= 80;
        2: ready_pct <= 50;
        default: ready_pct <= 25;
      endcase
    end else begin
      pattern_left <= pattern_left - 1;
    end
    out_ready <= ($urandom_range(1, 100) <= ready_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_out++;
      status_seen[out_status]++;
      if (awaited_picks.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got status %0d job %h ratio %h",
                 $time, out_status, out_chosen_job, out_response_ratio);
      end else begin
        want = awaited_picks.pop_front();
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
        end
        if (out_chosen_job !== want.chosen) begin
          errors++;
          $display("%0t: chosen job expected %h got %h", $time, want.chosen, out_chosen_job);
        end
        if (out_response_ratio !== want.ratio) begin
          errors++;
          $display("%0t: ratio expected %h got %h", $time, want.ratio, out_response_ratio);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_picks.size());
      $display("hrrn_ready_queue_selector test failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_policy(hrrn_pkg::FIFO);

    // fifo: empty select, extreme ids, estimates and times
    add_cmd(hrrn_pkg::CMD_SELECT, 16'h5a5a, 16'h1234, 32'h0000_0010);
    add_cmd(hrrn_pkg::CMD_PUSH, 16'h0000, 16'hffff, 32'hffff_ffff);
    add_cmd(hrrn_pkg::CMD_PUSH, 16'hffff, 16'h0000, 32'h0000_0000);
    add_cmd(hrrn_pkg::CMD_SELECT, 16'hffff, 16'hffff, 32'h0000_0005);
    add_cmd(hrrn_pkg::CMD_SELECT, 16'h0000, 16'h0000, 32'h8000_0000);
    add_cmd(hrrn_pkg::CMD_SELECT, 16'ha5a5, 16'h8001, 32'h8000_0001);
    drain_block();
    set_policy(hrrn_pkg::HRRN);

    // hrrn: zero estimate, largest estimate, ratio order
    add_cmd(hrrn_pkg::CMD_PUSH, 16'h1111, 16'h0000, 32'd100);
    add_cmd(hrrn_pkg::CMD_PUSH, 16'h2222, 16'hffff, 32'd100);
    add_cmd(hrrn_pkg::CMD_PUSH, 16'h3333, 16'h0001, 32'd200);
    add_cmd(hrrn_pkg::CMD_SELECT, 16'h0000, 16'h0000, 32'd300);
    add_cmd(hrrn_pkg::CMD_SELECT, 16'h0000, 16'h0000, 32'd300);
    add_cmd(hrrn_pkg::CMD_SELECT, 16'h0000, 16'h0000, 32'd300);
    // equal ratios go to the older job
    add_cmd(hrrn_pkg::CMD_PUSH, 16'h4444, 16'd5, 32'd1000);
    add_cmd(hrrn_pkg::CMD_PUSH, 16'h5555, 16'd5, 32'd1000);
    add_cmd(hrrn_pkg::CMD_SELECT, 16'h0000, 16'h0000, 32'd1010);
    add_cmd(hrrn_pkg::CMD_SELECT, 16'h0000, 16'h0000, 32'd1010);
    // longest possible wait saturates the ratio
    add_cmd(hrrn_pkg::CMD_PUSH, 16'h6666, 16'h0000, 32'd5);
    add_cmd(hrrn_pkg::CMD_SELECT, 16'h0000, 16'h0000, 32'd4);
    // clock wraps between push and select
    add_cmd(hrrn_pkg::CMD_PUSH, 16'h7777, 16'd3, 32'hffff_fff0);
    add_cmd(hrrn_pkg::CMD_SELECT, 16'h0000, 16'h0000, 32'h0000_0010);
    add_cmd(hrrn_pkg::CMD_SELECT, 16'h0000, 16'h0000, 32'h0000_0010);
    drain_block();

    sim_clock = 32'hffff_f000;
    queue_random(200);
    drain_block();
    set_policy(hrrn_pkg::FIFO);
    queue_random(100);
    drain_block();
    set_policy(hrrn_pkg::HRRN);
    queue_random(100);
    drain_block();
    repeat (40) @(posedge clk);

    $display("checked %0d result words: %0d pushes, %0d selections (%0d by ratio),",
             words_out, status_seen[hrrn_pkg::ST_PUSHED], status_seen[hrrn_pkg::ST_SELECTED],
             hrrn_picks);
    $display("%0d empty-table selects, %0d full-table drops, policy fifo/hrrn/fifo/hrrn",
             status_seen[hrrn_pkg::ST_EMPTY], status_seen[hrrn_pkg::ST_FULL]);
    if (errors == 0 && awaited_picks.size() == 0) begin
      $display("hrrn_ready_queue_selector test passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, awaited_picks.size());
      $display("hrrn_ready_queue_selector test failed");
    end
    $finish;
  end

endmodule
